@@ src/packet_header_parser_crc16_defines.svh @@
// Assertion macros shared by the packet header parser RTL.
`ifndef PACKET_HEADER_PARSER_CRC16_DEFINES_SVH
`define PACKET_HEADER_PARSER_CRC16_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

@@ src/phpcrc_pkg.sv @@
// Constants and the CRC byte step for the packet header parser.
package phpcrc_pkg;

    localparam int BYTE_W = 8;
    localparam int WORD_W = 16;

    localparam logic [WORD_W-1:0] CRC_POLY = 16'h1021;
    localparam logic [BYTE_W-1:0] CMD_CHECK = 8'hFF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One byte of the augmented CRC-16, shifted in MSB first.
    function automatic logic [WORD_W-1:0] crc_feed(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [WORD_W-1:0] r;
        logic              top;
        r = crc;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            top = r[WORD_W-1];
            r   = {r[WORD_W-2:0], data[i]};
            if (top)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

endpackage

@@ src/packet_header_parser_crc16.sv @@
// Packet header parser: signature hunt, header decode and header CRC-16.
`include "packet_header_parser_crc16_defines.svh"

// The parser takes one received byte per transaction and can accept a byte in
// every clock cycle. Each byte is captured in an input register and then
// processed by the phase logic and one unrolled eight-bit CRC step; the result
// is held in a result register, from which m_tvalid rises once the second
// length byte has been processed. s_tready drops only while that closing
// length byte waits behind a result that the master side has not yet taken.
// The host signature is to be written over the configuration channel only
// while the parser is idle; the block itself does not enforce this. A header
// is recognized once the last two bytes seen in the hunt equal the signature
// (low byte first). The result carries the status in m_tuser, and on a failed
// command check the command, length and CRC are all zero.
module packet_header_parser_crc16
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel: host signature.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,

    // Received byte stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    // Parsed header results.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] command, [23:8] data_count, [39:24] header_crc
    output logic        m_tuser    // [0] status
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_INV  = 3'd1,
        PH_LLO  = 3'd2,
        PH_LHI  = 3'd3
    } phase_t;

    logic [15:0] host_signature_reg;

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;

    phase_t      phase_reg,      phase_next;
    logic [15:0] shift_reg,      shift_next;
    logic [7:0]  command_reg,    command_next;
    logic [7:0]  inverse_reg,    inverse_next;
    logic [7:0]  length_low_reg, length_low_next;
    logic [15:0] crc_reg,        crc_next;

    logic        out_valid_reg;
    logic        out_status_reg, out_status_next;
    logic [7:0]  out_command_reg, out_command_next;
    logic [15:0] out_count_reg,   out_count_next;
    logic [15:0] out_crc_reg,     out_crc_next;

    logic        consume;
    logic        out_load;
    logic [15:0] crc_base;
    logic [15:0] crc_fed;

    // The stored byte moves on unless it closes a header while a result still waits.
    assign consume   = in_valid_reg &&
                       (phase_reg != PH_LHI || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || consume;
    assign cfg_ready = 1'b1;

    // The CRC restarts from zero on the command byte.
    assign crc_base = (phase_reg == PH_INV || phase_reg == PH_LLO || phase_reg == PH_LHI)
                      ? crc_reg : '0;
    assign crc_fed  = phpcrc_pkg::crc_feed(crc_base, in_byte_reg);

    // Phase logic for the stored byte.
    always_comb
    begin
        phase_next       = phase_reg;
        shift_next       = shift_reg;
        command_next     = command_reg;
        inverse_next     = inverse_reg;
        length_low_next  = length_low_reg;
        crc_next         = crc_reg;
        out_load         = 1'b0;
        out_status_next  = phpcrc_pkg::STATUS_OK;
        out_command_next = command_reg;
        out_count_next   = {in_byte_reg, length_low_reg};
        out_crc_next     = crc_fed;
        if (consume)
        begin
            unique case (phase_reg)
                PH_INV:
                begin
                    inverse_next = in_byte_reg;
                    crc_next     = crc_fed;
                    phase_next   = PH_LLO;
                end
                PH_LLO:
                begin
                    length_low_next = in_byte_reg;
                    crc_next        = crc_fed;
                    phase_next      = PH_LHI;
                end
                PH_LHI:
                begin
                    crc_next   = crc_fed;
                    out_load   = 1'b1;
                    phase_next = PH_HUNT;
                    shift_next = '0;
                    if ((command_reg ^ inverse_reg) != phpcrc_pkg::CMD_CHECK)
                    begin
                        out_status_next  = phpcrc_pkg::STATUS_ERR;
                        out_command_next = '0;
                        out_count_next   = '0;
                        out_crc_next     = '0;
                    end
                end
                default:
                begin
                    // Signature hunt; unused codes behave the same way.
                    if (shift_reg == host_signature_reg)
                    begin
                        command_next = in_byte_reg;
                        crc_next     = crc_fed;
                        phase_next   = PH_INV;
                    end
                    else
                    begin
                        shift_next = {in_byte_reg, shift_reg[15:8]};
                        phase_next = PH_HUNT;
                    end
                end
            endcase
        end
    end

    // State, input register and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_signature_reg <= '0;
            in_valid_reg       <= 1'b0;
            in_byte_reg        <= '0;
            phase_reg          <= PH_HUNT;
            shift_reg          <= '0;
            command_reg        <= '0;
            inverse_reg        <= '0;
            length_low_reg     <= '0;
            crc_reg            <= '0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= phpcrc_pkg::STATUS_OK;
            out_command_reg    <= '0;
            out_count_reg      <= '0;
            out_crc_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                host_signature_reg <= cfg_data;
            end

            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_byte_reg  <= s_tdata;
            end
            else if (consume)
            begin
                in_valid_reg <= 1'b0;
            end

            phase_reg      <= phase_next;
            shift_reg      <= shift_next;
            command_reg    <= command_next;
            inverse_reg    <= inverse_next;
            length_low_reg <= length_low_next;
            crc_reg        <= crc_next;

            if (out_load)
            begin
                out_valid_reg   <= 1'b1;
                out_status_reg  <= out_status_next;
                out_command_reg <= out_command_next;
                out_count_reg   <= out_count_next;
                out_crc_reg     <= out_crc_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_crc_reg, out_count_reg, out_command_reg};

    // A failed command check reports nothing but its status.
    `ASSERT_ALWAYS(a_err_payload_zero, m_tvalid && m_tuser == phpcrc_pkg::STATUS_ERR |-> m_tdata == '0, "error result with nonzero payload")
    // A new result never overwrites one that is still waiting.
    `ASSERT_NEVER(a_no_overwrite, out_load && out_valid_reg && !m_tready, "pending result overwritten")
    // After a result the parser is back in the hunt with a cleared shift register.
    `ASSERT_ALWAYS(a_back_to_hunt, out_load |=> phase_reg == PH_HUNT && shift_reg == '0, "no return to hunt after result")
    // A hunt byte that does not complete the signature keeps the parser hunting.
    `ASSERT_ALWAYS(a_hunt_holds, consume && phase_reg == PH_HUNT && shift_reg != host_signature_reg |=> phase_reg == PH_HUNT, "hunt left without signature match")

endmodule
